/* sv/fgrb_pkg.sv */
// Shared types and codes for the frame grouped ring buffer.
// No dependencies; the top level takes everything from here by scoped names.
package fgrb_pkg;

  localparam int unsigned LEN_W  = 7;
  localparam int unsigned WORD_W = 64;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_POP    = 2'd2,
    CMD_COPY   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NO_FRAME = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_WALK,
    S_CLAMP,
    S_SETUP,
    S_EMIT
  } state_e;

  typedef struct packed {
    cmd_e              command;
    logic [LEN_W-1:0]  frame_length;
    logic [WORD_W-1:0] meas_word;
    logic [LEN_W-1:0]  dest_capacity;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic              has_data;
    logic [WORD_W-1:0] out_word;
    logic              last;
    logic [LEN_W-1:0]  copied_total;
  } rsp_t;

endpackage

/* sv/frame_grouped_ring_buffer_unit.sv */
// Frame grouped ring buffer: element memory, frame length memory and control.
// Depends on fgrb_pkg for the command, status, state and word types.
//
// Header and push give their result in the cycle after acceptance; pushes stream one per cycle.
// Pop answers from S_POP, since the frame length comes from the length memory read port.
// Copyout walks the length memory one frame per cycle from the newest frame back, sizes
// the range in S_CLAMP and S_SETUP, then emits one word per cycle from the element memory.
// The receiver cannot stall. Reset clears pointers and counts at once; memories are not cleared.
module frame_grouped_ring_buffer_unit #(
  parameter int unsigned ELEM_DEPTH  = 64,
  parameter int unsigned FRAME_DEPTH = 16,
  parameter int unsigned ELEM_WIDTH  = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  fgrb_pkg::req_t req_i,
  output logic           rsp_valid_o,
  output fgrb_pkg::rsp_t rsp_o
);

  localparam int unsigned AW  = $clog2(ELEM_DEPTH);
  localparam int unsigned CW  = $clog2(ELEM_DEPTH + 1);
  localparam int unsigned FW  = $clog2(FRAME_DEPTH);
  localparam int unsigned FCW = $clog2(FRAME_DEPTH + 1);
  localparam int unsigned LW  = fgrb_pkg::LEN_W;
  localparam int unsigned SW  = fgrb_pkg::LEN_W + 1;

  // Memories.
  logic [ELEM_WIDTH-1:0] elem_mem [ELEM_DEPTH];
  logic [LW-1:0]         len_mem  [FRAME_DEPTH];

  logic                  elem_we;
  logic [AW-1:0]         elem_waddr, elem_raddr;
  logic [ELEM_WIDTH-1:0] elem_rdata;
  logic                  len_we;
  logic [FW-1:0]         len_waddr, len_raddr;
  logic [LW-1:0]         len_wdata, len_rdata;

  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      elem_mem[elem_waddr] <= req_i.meas_word[ELEM_WIDTH-1:0];
    end
    elem_rdata <= elem_mem[elem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_rdata <= len_mem[len_raddr];
  end

  // Ring arithmetic; the amount never exceeds the element depth.
  function automatic logic [AW-1:0] add_wrap(logic [AW-1:0] ptr, logic [LW-1:0] amt);
    logic [SW-1:0] s;
    s = SW'(ptr) + SW'(amt);
    if (s >= SW'(ELEM_DEPTH)) s = s - SW'(ELEM_DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] sub_wrap(logic [AW-1:0] ptr, logic [LW-1:0] amt);
    logic [SW-1:0] s;
    s = SW'(ptr) + SW'(ELEM_DEPTH) - SW'(amt);
    if (s >= SW'(ELEM_DEPTH)) s = s - SW'(ELEM_DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic [FW-1:0] finc(logic [FW-1:0] p);
    return (p == FW'(FRAME_DEPTH - 1)) ? '0 : p + FW'(1);
  endfunction

  function automatic logic [FW-1:0] fdec(logic [FW-1:0] p);
    return (p == '0) ? FW'(FRAME_DEPTH - 1) : p - FW'(1);
  endfunction

  // State.
  fgrb_pkg::state_e state_q, state_d;
  logic [AW-1:0]  ewp_q, ewp_d, erp_q, erp_d;
  logic [CW-1:0]  ecnt_q, ecnt_d;
  logic [FW-1:0]  fwp_q, fwp_d, frp_q, frp_d;
  logic [FCW-1:0] fcnt_q, fcnt_d;
  logic [LW-1:0]  open_rem_q, open_rem_d, open_len_q, open_len_d;

  // Copyout working registers.
  logic [FW-1:0]  idx_q, idx_d;
  logic [FCW-1:0] walked_q, walked_d;
  logic [LW-1:0]  total_q, total_d, cap_q, cap_d, rem_q, rem_d;
  logic [AW-1:0]  end_q, end_d, rd_ptr_q, rd_ptr_d;

  logic           rsp_valid_q, rsp_valid_d;
  fgrb_pkg::rsp_t rsp_q, rsp_d;

  logic           accept;
  logic [SW-1:0]  walk_sum;
  logic           walk_fits;
  logic [FCW-1:0] walked_inc;
  logic [LW-1:0]  pending, avail, clamped, pop_len;
  logic [AW-1:0]  start_ptr;

  assign accept      = start_i && (state_q == fgrb_pkg::S_IDLE);
  assign busy_o      = (state_q != fgrb_pkg::S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign walk_sum   = SW'(total_q) + SW'(len_rdata);
  assign walk_fits  = (walk_sum <= SW'(cap_q));
  assign walked_inc = walked_q + FCW'(1);
  // Elements of the open frame already pushed are not part of any committed frame.
  assign pending    = (open_rem_q != '0) ? (open_len_q - open_rem_q) : '0;
  assign avail      = LW'(ecnt_q) - pending;
  assign clamped    = (total_q > avail) ? avail : total_q;
  assign pop_len    = (len_rdata > LW'(ecnt_q)) ? LW'(ecnt_q) : len_rdata;
  assign start_ptr  = sub_wrap(end_q, total_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fgrb_pkg::S_IDLE: begin
        if (accept && fcnt_q != '0) begin
          if (req_i.command == fgrb_pkg::CMD_POP) state_d = fgrb_pkg::S_POP;
          if (req_i.command == fgrb_pkg::CMD_COPY) state_d = fgrb_pkg::S_WALK;
        end
      end
      fgrb_pkg::S_POP: state_d = fgrb_pkg::S_IDLE;
      fgrb_pkg::S_WALK: begin
        if (!walk_fits || walked_inc == fcnt_q) state_d = fgrb_pkg::S_CLAMP;
      end
      fgrb_pkg::S_CLAMP: state_d = (clamped == '0) ? fgrb_pkg::S_IDLE : fgrb_pkg::S_SETUP;
      fgrb_pkg::S_SETUP: state_d = fgrb_pkg::S_EMIT;
      fgrb_pkg::S_EMIT: begin
        if (rem_q == LW'(1)) state_d = fgrb_pkg::S_IDLE;
      end
      default: state_d = fgrb_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    ewp_d      = ewp_q;
    erp_d      = erp_q;
    ecnt_d     = ecnt_q;
    fwp_d      = fwp_q;
    frp_d      = frp_q;
    fcnt_d     = fcnt_q;
    open_rem_d = open_rem_q;
    open_len_d = open_len_q;
    idx_d      = idx_q;
    walked_d   = walked_q;
    total_d    = total_q;
    cap_d      = cap_q;
    rem_d      = rem_q;
    end_d      = end_q;
    rd_ptr_d   = rd_ptr_q;

    elem_we    = 1'b0;
    elem_waddr = ewp_q;
    elem_raddr = rd_ptr_q;
    len_we     = 1'b0;
    len_waddr  = fwp_q;
    len_wdata  = req_i.frame_length;
    len_raddr  = frp_q;

    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;

    unique case (state_q)
      fgrb_pkg::S_IDLE: begin
        if (accept) begin
          rsp_valid_d        = 1'b1;
          rsp_d.status       = fgrb_pkg::ST_OK;
          rsp_d.has_data     = 1'b0;
          rsp_d.out_word     = '0;
          rsp_d.last         = 1'b1;
          rsp_d.copied_total = '0;
          rsp_valid_d        = 1'b1;
          unique case (req_i.command)
            fgrb_pkg::CMD_HEADER: begin
              if (open_rem_q != '0 || fcnt_q >= FCW'(FRAME_DEPTH) ||
                  req_i.frame_length > LW'(CW'(ELEM_DEPTH) - ecnt_q)) begin
                rsp_d.status = fgrb_pkg::ST_NO_SPACE;
              end else begin
                len_we = 1'b1;
                if (req_i.frame_length == '0) begin
                  fwp_d  = finc(fwp_q);
                  fcnt_d = fcnt_q + FCW'(1);
                end else begin
                  open_rem_d = req_i.frame_length;
                  open_len_d = req_i.frame_length;
                end
              end
            end
            fgrb_pkg::CMD_PUSH: begin
              if (open_rem_q == '0) begin
                rsp_d.status = fgrb_pkg::ST_NO_FRAME;
              end else begin
                elem_we    = 1'b1;
                ewp_d      = add_wrap(ewp_q, LW'(1));
                ecnt_d     = ecnt_q + CW'(1);
                open_rem_d = open_rem_q - LW'(1);
                if (open_rem_q == LW'(1)) begin
                  fwp_d  = finc(fwp_q);
                  fcnt_d = fcnt_q + FCW'(1);
                end
              end
            end
            fgrb_pkg::CMD_POP: begin
              if (fcnt_q == '0) begin
                rsp_d.status = fgrb_pkg::ST_EMPTY;
              end else begin
                rsp_valid_d = 1'b0;
              end
            end
            fgrb_pkg::CMD_COPY: begin
              if (fcnt_q == '0) begin
                rsp_d.status = fgrb_pkg::ST_EMPTY;
              end else begin
                // Start the walk at the newest committed frame.
                rsp_valid_d = 1'b0;
                len_raddr   = fdec(fwp_q);
                idx_d       = fdec(fwp_q);
                walked_d    = '0;
                total_d     = '0;
                cap_d       = req_i.dest_capacity;
              end
            end
            default: ;
          endcase
        end
      end
      fgrb_pkg::S_POP: begin
        frp_d              = finc(frp_q);
        fcnt_d             = fcnt_q - FCW'(1);
        erp_d              = add_wrap(erp_q, pop_len);
        ecnt_d             = ecnt_q - CW'(pop_len);
        rsp_valid_d        = 1'b1;
        rsp_d.status       = fgrb_pkg::ST_OK;
        rsp_d.has_data     = 1'b0;
        rsp_d.out_word     = '0;
        rsp_d.last         = 1'b1;
        rsp_d.copied_total = '0;
      end
      fgrb_pkg::S_WALK: begin
        len_raddr = fdec(idx_q);
        if (walk_fits) begin
          total_d  = walk_sum[LW-1:0];
          walked_d = walked_inc;
          idx_d    = fdec(idx_q);
        end
      end
      fgrb_pkg::S_CLAMP: begin
        total_d = clamped;
        end_d   = sub_wrap(ewp_q, pending);
        if (clamped == '0) begin
          rsp_valid_d        = 1'b1;
          rsp_d.status       = fgrb_pkg::ST_OK;
          rsp_d.has_data     = 1'b0;
          rsp_d.out_word     = '0;
          rsp_d.last         = 1'b1;
          rsp_d.copied_total = '0;
        end
      end
      fgrb_pkg::S_SETUP: begin
        elem_raddr = start_ptr;
        rd_ptr_d   = add_wrap(start_ptr, LW'(1));
        rem_d      = total_q;
      end
      fgrb_pkg::S_EMIT: begin
        rsp_valid_d        = 1'b1;
        rsp_d.status       = fgrb_pkg::ST_OK;
        rsp_d.has_data     = 1'b1;
        rsp_d.out_word     = fgrb_pkg::WORD_W'(elem_rdata);
        rsp_d.last         = (rem_q == LW'(1));
        rsp_d.copied_total = total_q;
        rd_ptr_d           = add_wrap(rd_ptr_q, LW'(1));
        rem_d              = rem_q - LW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fgrb_pkg::S_IDLE;
      ewp_q       <= '0;
      erp_q       <= '0;
      ecnt_q      <= '0;
      fwp_q       <= '0;
      frp_q       <= '0;
      fcnt_q      <= '0;
      open_rem_q  <= '0;
      open_len_q  <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ewp_q       <= ewp_d;
      erp_q       <= erp_d;
      ecnt_q      <= ecnt_d;
      fwp_q       <= fwp_d;
      frp_q       <= frp_d;
      fcnt_q      <= fcnt_d;
      open_rem_q  <= open_rem_d;
      open_len_q  <= open_len_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    walked_q <= walked_d;
    total_q  <= total_d;
    cap_q    <= cap_d;
    rem_q    <= rem_d;
    end_q    <= end_d;
    rd_ptr_q <= rd_ptr_d;
    rsp_q    <= rsp_d;
  end

endmodule
